FILE: rtl/c3lb_pkg.sv
// Package for the 3x3 convolution line-buffer stencil.
// Word types, coefficient type, register indexes and reset values.
// No dependencies.
package c3lb_pkg;

	localparam int PIX_W   = 16;
	localparam int COEF_W  = 12;
	localparam int COEF_N  = 9;
	localparam int PROD_W  = PIX_W + 1 + COEF_W;
	localparam int SUM_W   = 32;
	localparam int CFG_W   = 60;
	localparam int LW_W    = 9;

	localparam logic [1:0] REG_COEF_LOW   = 2'd0;
	localparam logic [1:0] REG_COEF_HIGH  = 2'd1;
	localparam logic [1:0] REG_LINE_WIDTH = 2'd2;

	localparam logic [59:0]     COEF_LOW_RESET   = 60'h010040020040020;
	localparam logic [47:0]     COEF_HIGH_RESET  = 48'h020040020040;
	localparam logic [LW_W-1:0] LINE_WIDTH_RESET = 9'd256;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		pixel_t pixel;
		logic   first_of_frame;
		logic   last_of_frame;
	} in_word_t;

	typedef struct packed {
		sum_t filtered_value;
		logic frame_done;
	} out_word_t;

	// one column entering the window
	typedef struct packed {
		pixel_t pixel;
		pixel_t up1;
		pixel_t up2;
		logic   produce;
		logic   last;
	} col_word_t;

endpackage

FILE: rtl/conv3x3_line_buffer_stencil.sv
// Top level of the 3x3 convolution line-buffer stencil.
// Config registers, line buffer and multiply-accumulate pipeline.
// Depends on c3lb_pkg, c3lb_line_buf, c3lb_mac.
//
//   port group   dir  handshake            word
//   in_*         in   in_valid/in_ready    in_word_t: pixel, first/last of frame
//   out_*        out  out_valid/out_ready  out_word_t: filtered_value, frame_done
//   cfg_*        in   cfg_wr_en only       cfg_index, cfg_data
//
// One word per clock in while no stall backs up from out_ready, and at most
// one per clock out, one result per completed window. Registers from input to
// output: line store read, then window, products, partial sums, sum.
// arst_n clears counters, pipeline valids and window, and loads config reset values.
// A stall at out_ready fills the free stages behind it before in_ready drops.
module conv3x3_line_buffer_stencil import c3lb_pkg::*; #(
	parameter int MAX_COLS = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_word_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_word_t        out_data,
	input  logic             cfg_wr_en,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [59:0]     coef_low_q;
	logic [47:0]     coef_high_q;
	logic [LW_W-1:0] line_width_q;
	coef_t [COEF_N-1:0] coef;

	logic      col_valid;
	logic      col_ready;
	col_word_t col_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_low_q   <= COEF_LOW_RESET;
			coef_high_q  <= COEF_HIGH_RESET;
			line_width_q <= LINE_WIDTH_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_COEF_LOW:   coef_low_q   <= cfg_data[59:0];
				REG_COEF_HIGH:  coef_high_q  <= cfg_data[47:0];
				REG_LINE_WIDTH: line_width_q <= cfg_data[LW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < 5; k++) begin
			coef[k] = coef_low_q[COEF_W*k +: COEF_W];
		end
		for (int k = 0; k < 4; k++) begin
			coef[k+5] = coef_high_q[COEF_W*k +: COEF_W];
		end
	end

	c3lb_line_buf #(
		.MAX_COLS(MAX_COLS)
	) u_line_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.line_width (line_width_q),
		.col_valid  (col_valid),
		.col_ready  (col_ready),
		.col_data   (col_data)
	);

	c3lb_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.col_valid  (col_valid),
		.col_ready  (col_ready),
		.col_data   (col_data),
		.coef       (coef),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

`ifndef SYNTHESIS
	// input side only stalls when the column word is stuck
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!col_valid || col_ready))
		else $error("in_ready does not follow column stage");

	// a frame start sits in column zero and cannot complete a window
	a_first_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.first_of_frame)
		|=> (col_valid && !col_data.produce))
		else $error("first word of frame marked as producing");

	// stalled column word holds
	a_col_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(col_valid && !col_ready) |=> (col_valid && $stable(col_data)))
		else $error("column word changed while stalled");
`endif

endmodule

FILE: rtl/c3lb_line_buf.sv
// Line stores, column/row counters and the first pipeline stage.
// Emits one column word (current pixel and the two above) per input word.
// Depends on c3lb_pkg.
module c3lb_line_buf import c3lb_pkg::*; #(
	parameter int MAX_COLS = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  in_word_t        in_data,
	input  logic [LW_W-1:0] line_width,
	output logic            col_valid,
	input  logic            col_ready,
	output col_word_t       col_data
);

	localparam int AW = $clog2(MAX_COLS);
	localparam int WW = ($clog2(MAX_COLS + 1) > LW_W) ? $clog2(MAX_COLS + 1) : LW_W;
	localparam logic [WW-1:0] MAX_W = WW'(MAX_COLS);
	localparam logic [WW-1:0] MIN_W = WW'(3);

	logic [AW-1:0] col_q;
	logic [1:0]    phase_q;
	logic          v_s1;

	pixel_t        line1_mem [MAX_COLS];
	pixel_t        line2_mem [MAX_COLS];

	pixel_t        px_s1;
	pixel_t        up1_s1;
	pixel_t        rd2_s1;
	pixel_t        fwd_px_s1;
	logic          fwd_s1;
	logic [AW-1:0] c_s1;
	logic          produce_s1;
	logic          last_s1;

	logic          accept;
	logic [WW-1:0] width_ext;
	logic [WW-1:0] w_used;
	logic [AW-1:0] c;
	logic [1:0]    phase;
	logic [WW-1:0] c_next;
	logic          row_end;
	logic          produce;
	logic          fwd_hit;

	assign in_ready = !v_s1 || col_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		width_ext = WW'(line_width);
		if (width_ext < MIN_W) begin
			w_used = MIN_W;
		end else if (width_ext > MAX_W) begin
			w_used = MAX_W;
		end else begin
			w_used = width_ext;
		end
		c       = in_data.first_of_frame ? '0 : col_q;
		phase   = in_data.first_of_frame ? 2'd0 : phase_q;
		c_next  = WW'(c) + WW'(1);
		row_end = c_next >= w_used;
		produce = (phase == 2'd2) && (c >= AW'(2));
		fwd_hit = v_s1 && (c_s1 == c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			phase_q <= 2'd0;
			v_s1    <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (accept) begin
				if (row_end) begin
					col_q   <= '0;
					phase_q <= (phase == 2'd2) ? 2'd2 : phase + 2'd1;
				end else begin
					col_q   <= c_next[AW-1:0];
					phase_q <= phase;
				end
			end
		end
	end

	// second store takes the older line once the stage-1 word is known
	always_ff @(posedge clk) begin
		if (accept) begin
			up1_s1        <= line1_mem[c];
			line1_mem[c]  <= in_data.pixel;
			rd2_s1        <= line2_mem[c];
			fwd_s1        <= fwd_hit;
			fwd_px_s1     <= up1_s1;
			px_s1         <= in_data.pixel;
			c_s1          <= c;
			produce_s1    <= produce;
			last_s1       <= in_data.last_of_frame;
		end
		if (v_s1) begin
			line2_mem[c_s1] <= up1_s1;
		end
	end

	assign col_valid        = v_s1;
	assign col_data.pixel   = px_s1;
	assign col_data.up1     = up1_s1;
	assign col_data.up2     = fwd_s1 ? fwd_px_s1 : rd2_s1;
	assign col_data.produce = produce_s1;
	assign col_data.last    = last_s1;

endmodule

FILE: rtl/c3lb_mac.sv
// 3x3 window, nine coefficient products and the sum pipeline.
// Window shift, product stage, partial sums, output register.
// Depends on c3lb_pkg.
module c3lb_mac import c3lb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   col_valid,
	output logic                   col_ready,
	input  col_word_t              col_data,
	input  coef_t [COEF_N-1:0]     coef,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_word_t              out_data
);

	pixel_t win_q [COEF_N];
	logic   v_s2, v_s3, v_s4, v_s5;
	logic   last_s2, last_s3, last_s4;
	prod_t  prod_s3 [COEF_N];
	sum_t   part_s4 [3];
	logic   en_s2, en_s3, en_s4, en_s5;

	assign en_s5     = !v_s5 || out_ready;
	assign en_s4     = !v_s4 || en_s5;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign col_ready = en_s2;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int k = 0; k < COEF_N; k++) begin
				win_q[k] <= '0;
			end
		end else begin
			if (en_s2) begin
				v_s2 <= col_valid && col_data.produce;
				if (col_valid) begin
					for (int r = 0; r < 3; r++) begin
						win_q[3*r]   <= win_q[3*r+1];
						win_q[3*r+1] <= win_q[3*r+2];
					end
					win_q[2] <= col_data.up2;
					win_q[5] <= col_data.up1;
					win_q[8] <= col_data.pixel;
				end
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && col_valid) begin
			last_s2 <= col_data.last;
		end
		if (en_s3 && v_s2) begin
			last_s3 <= last_s2;
			for (int k = 0; k < COEF_N; k++) begin
				prod_s3[k] <= $signed({1'b0, win_q[k]}) * coef[k];
			end
		end
		if (en_s4 && v_s3) begin
			last_s4 <= last_s3;
			for (int r = 0; r < 3; r++) begin
				part_s4[r] <= SUM_W'(prod_s3[3*r]) + SUM_W'(prod_s3[3*r+1])
					+ SUM_W'(prod_s3[3*r+2]);
			end
		end
		if (en_s5 && v_s4) begin
			out_data.filtered_value <= part_s4[0] + part_s4[1] + part_s4[2];
			out_data.frame_done     <= last_s4;
		end
	end

endmodule

FILE: bench/tb_conv3x3_line_buffer_stencil.sv
`timescale 1ns / 100ps
// Testbench for conv3x3_line_buffer_stencil: directed and random pixel frames over
// several line widths and coefficient sets, each sum checked against a local predictor.
// Depends on c3lb_pkg and the stencil RTL.
module tb_conv3x3_line_buffer_stencil;
	import c3lb_pkg::*;

	localparam int         LINE_MAX    = 256;
	localparam int         NUM_PHASES  = 10;
	localparam int         SETTLE      = 12;
	localparam int         CYCLE_LIMIT = 200000;
	localparam logic [1:0] REG_SPARE   = 2'd3;

	// {pixel, first_of_frame, last_of_frame}, three pixels per row
	localparam logic [17:0] DIRECTED [21] = '{
		{16'h0000, 2'b10}, {16'h0000, 2'b01}, {16'h0000, 2'b00},
		{16'h0000, 2'b00}, {16'h0000, 2'b00}, {16'hFFFF, 2'b00},
		{16'hFFFF, 2'b00}, {16'hFFFF, 2'b00}, {16'hFFFF, 2'b00},
		{16'hFFFF, 2'b00}, {16'hFFFF, 2'b00}, {16'hFFFF, 2'b00},
		{16'h0000, 2'b00}, {16'h0000, 2'b00}, {16'hFFFF, 2'b01},
		{16'h0001, 2'b00}, {16'h5555, 2'b00}, {16'hAAAA, 2'b01},
		{16'h8000, 2'b10}, {16'h7FFF, 2'b00}, {16'hFFFF, 2'b01}
	};

	localparam logic [LW_W-1:0] PHASE_WIDTH [NUM_PHASES] = '{
		9'd6, 9'd0, 9'd9, 9'd4, 9'd16, 9'd1, 9'd7, 9'd3, 9'd511, 9'd2
	};

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_word_t         in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_word_t        out_data;
	logic             cfg_wr_en = 1'b0;
	logic [1:0]       cfg_index = REG_COEF_LOW;
	logic [CFG_W-1:0] cfg_data  = '0;

	// predictor state
	logic [59:0]     coef_low_r   = COEF_LOW_RESET;
	logic [47:0]     coef_high_r  = COEF_HIGH_RESET;
	logic [LW_W-1:0] line_width_r = LINE_WIDTH_RESET;
	pixel_t          line_mem [2*LINE_MAX] = '{default: '0};
	pixel_t          win [9] = '{default: '0};
	int unsigned     col_cnt   = 0;
	int unsigned     rows_done = 0;

	in_word_t  pending_pixels [$];
	out_word_t expected_sums [$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int errors        = 0;
	int pixels_sent   = 0;
	int sums_checked  = 0;
	int frame_ends    = 0;
	int cycles        = 0;

	always #6 clk = ~clk;

	conv3x3_line_buffer_stencil #(.MAX_COLS(LINE_MAX)) i_dut (.*);

	function automatic int unsigned used_width(input logic [LW_W-1:0] w);
		if (w < 3) return 3;
		if (w > LINE_MAX) return LINE_MAX;
		return w;
	endfunction

	function automatic longint coef_value(input int k);
		coef_t cv;
		if (k < 5) cv = coef_t'(coef_low_r >> (12 * k));
		else cv = coef_t'(coef_high_r >> (12 * (k - 5)));
		return longint'(cv);
	endfunction

	task automatic conv_predict(input in_word_t w);
		int unsigned wd, c;
		pixel_t up1, up2;
		logic produce;
		longint acc;
		out_word_t res;
		int k;
		wd = used_width(line_width_r);
		if (w.first_of_frame) begin
			col_cnt = 0;
			rows_done = 0;
		end
		c = col_cnt % LINE_MAX;
		up1 = line_mem[c];
		up2 = line_mem[LINE_MAX + c];
		line_mem[LINE_MAX + c] = up1;
		line_mem[c] = w.pixel;
		for (k = 0; k < 3; k++) begin
			win[3*k]   = win[3*k + 1];
			win[3*k+1] = win[3*k + 2];
		end
		win[2] = up2;
		win[5] = up1;
		win[8] = w.pixel;
		produce = (rows_done >= 2) && (c >= 2);
		if (c + 1 >= wd) begin
			col_cnt = 0;
			if (rows_done < 2) rows_done++;
		end else begin
			col_cnt = c + 1;
		end
		if (produce) begin
			acc = 0;
			for (k = 0; k < 9; k++)
				acc += coef_value(k) * longint'(win[k]);
			res.filtered_value = sum_t'(acc);
			res.frame_done = w.last_of_frame;
			expected_sums.push_back(res);
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				conv_predict(in_data);
				pixels_sent++;
			end
			if (!in_valid || in_ready) begin
				if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_data <= pending_pixels.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : monitor
		out_word_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_sums.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, expected none, got %0d", $time,
						$signed(out_data.filtered_value));
				end else begin
					want = expected_sums.pop_front();
					sums_checked++;
					if (out_data.frame_done === 1'b1) frame_ends++;
					if (out_data.filtered_value !== want.filtered_value) begin
						errors++;
						$display("%0t: filtered_value expected %0d, got %0d", $time,
							$signed(want.filtered_value), $signed(out_data.filtered_value));
					end
					if (out_data.frame_done !== want.frame_done) begin
						errors++;
						$display("%0t: frame_done expected %b, got %b", $time,
							want.frame_done, out_data.frame_done);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d sums still due", cycles, expected_sums.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_COEF_LOW: coef_low_r = val;
			REG_COEF_HIGH: coef_high_r = val[47:0];
			REG_LINE_WIDTH: line_width_r = val[LW_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_pixels.size() != 0 || in_valid || expected_sums.size() != 0);
	endtask

	function automatic pixel_t rand_pixel();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) return '0;
		if (pick == 1) return '1;
		return pixel_t'($urandom_range(16'hFFFF));
	endfunction

	function automatic logic [CFG_W-1:0] rand_coefs();
		logic [CFG_W-1:0] v;
		int k;
		v = CFG_W'({$urandom, $urandom});
		for (k = 0; k < 5; k++) begin
			case ($urandom_range(5))
				0: v[12*k +: 12] = 12'h7FF;
				1: v[12*k +: 12] = 12'h800;
				default: ;
			endcase
		end
		return v;
	endfunction

	task automatic queue_pixel(input pixel_t p, input logic f, input logic l);
		in_word_t w;
		w.pixel = p;
		w.first_of_frame = f;
		w.last_of_frame = l;
		pending_pixels.push_back(w);
	endtask

	task automatic queue_frame(input int unsigned wd, input int rows, input int extra,
			input logic with_last);
		int n, total;
		total = rows * wd + extra;
		for (n = 0; n < total; n++)
			queue_pixel(rand_pixel(), n == 0, with_last && n == total - 1);
	endtask

	// stray flags, no frame structure
	task automatic queue_noise(input int count);
		int n;
		for (n = 0; n < count; n++)
			queue_pixel(rand_pixel(), $urandom_range(19) == 0, $urandom_range(9) == 0);
	endtask

	task automatic queue_phase(input int unsigned wd, input int budget, input bit resume);
		int queued, kind, rows, len;
		queued = 0;
		if (resume) begin
			len = $urandom_range(2 * wd, 4 * wd);
			queue_noise(len);
			queued += len;
		end else begin
			rows = $urandom_range(3, 5);
			queue_frame(wd, rows, 0, 1'b1);
			queued += rows * wd;
		end
		while (queued < budget) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				rows = $urandom_range(3, 6);
				queue_frame(wd, rows, 0, 1'b1);
				queued += rows * wd;
			end else if (kind < 78) begin
				rows = $urandom_range(1, 2);
				queue_frame(wd, rows, 0, 1'b1);
				queued += rows * wd;
			end else if (kind < 90) begin
				len = $urandom_range(1, 4 * wd);
				queue_frame(wd, 0, len, 1'($urandom_range(1)));
				queued += len;
			end else begin
				len = $urandom_range(1, 3 * wd);
				queue_noise(len);
				queued += len;
			end
		end
	endtask

	initial begin : stimulus
		int ph, n, tail;
		int unsigned wd, prev_wd;
		bit resume;
		logic [CFG_W-1:0] junk;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// narrowest rows, largest coefficients low, most negative high
		send_idle_pct = 10;
		stall_pct = 85;
		write_reg(REG_LINE_WIDTH, CFG_W'(3));
		write_reg(REG_COEF_LOW, {5{12'h7FF}});
		write_reg(REG_COEF_HIGH, {12'hABC, {4{12'h800}}});
		@(negedge clk);
		for (n = 0; n < 21; n++)
			queue_pixel(DIRECTED[n][17:2], DIRECTED[n][1], DIRECTED[n][0]);
		prev_wd = 3;

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			repeat (SETTLE) @(posedge clk);
			if (ph == 4) begin
				send_idle_pct = 85;
				stall_pct = 10;
			end
			if (ph == 7) begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			wd = used_width(PHASE_WIDTH[ph]);
			// rows no wider than before may pick up mid-row without a new frame
			resume = (wd <= prev_wd) && (ph == 7 || $urandom_range(1) == 1);
			junk = CFG_W'({$urandom, $urandom});
			junk[LW_W-1:0] = PHASE_WIDTH[ph];
			write_reg(REG_LINE_WIDTH, junk);
			if (ph == 0) begin
				write_reg(REG_COEF_LOW, COEF_LOW_RESET);
				write_reg(REG_COEF_HIGH, {12'h5A5, COEF_HIGH_RESET});
			end else begin
				write_reg(REG_COEF_LOW, rand_coefs());
				write_reg(REG_COEF_HIGH, rand_coefs());
			end
			write_reg(REG_SPARE, CFG_W'({$urandom, $urandom}));
			@(negedge clk);
			if (ph == 8) begin
				queue_frame(wd, 2, 14, 1'b1);
			end else begin
				if (ph == 2) begin
					queue_phase(wd, 40, resume);
					wait_idle();
					queue_phase(wd, 40, 1'b1);
				end else begin
					queue_phase(wd, 85, resume);
				end
				tail = (ph == 6) ? 5 : $urandom_range(wd - 1);
				for (n = 0; n < tail; n++)
					queue_pixel(rand_pixel(), 1'b0, 1'b0);
			end
			prev_wd = wd;
		end

		wait_idle();
		repeat (SETTLE) @(posedge clk);
		if (expected_sums.size() != 0) begin
			errors++;
			$display("%0t: %0d sums never arrived", $time, expected_sums.size());
		end
		$display("Run covered %0d pixels over %0d width/coefficient settings,", pixels_sent,
			NUM_PHASES + 1);
		$display("%0d sums checked, %0d of them closing a frame.", sums_checked, frame_ends);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

FILE: conv3x3_line_buffer_stencil.f
rtl/c3lb_pkg.sv
rtl/c3lb_line_buf.sv
rtl/c3lb_mac.sv
rtl/conv3x3_line_buffer_stencil.sv
bench/tb_conv3x3_line_buffer_stencil.sv
